>>> rtl/mcch_pkg.sv
// shared types, constants and state codes for the convex hull block
package mcch_pkg;

  localparam int MAX_POINTS = 32;
  localparam int COORD_BITS = 16;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int STK_DEPTH  = 2 * MAX_POINTS;
  localparam int STK_AW     = $clog2(STK_DEPTH);
  localparam int LEN_W      = $clog2(STK_DEPTH + 1);
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CQ_DEPTH   = 4;
  localparam int CQ_AW      = $clog2(CQ_DEPTH);
  localparam int OQ_DEPTH   = 4;
  localparam int OQ_AW      = $clog2(OQ_DEPTH);

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_FEW = 2'd1;
  localparam logic [1:0] ST_OV  = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] hull_x;
    logic signed [COORD_BITS-1:0] hull_y;
    logic                         last_out;
    logic [1:0]                   status;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  typedef enum logic [2:0] {
    CMD_STORE,
    CMD_TRIPLE,
    CMD_HULL,
    CMD_ERR_FEW,
    CMD_ERR_OV
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    point_t    pt;
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_ERR,
    B_TRIPLE,
    B_PUSH,
    B_DIFF,
    B_MUL,
    B_CMP,
    B_RELOAD,
    B_NEXT,
    B_LPUSH0,
    B_LPUSH1,
    B_EMIT_RD,
    B_EMIT_WR
  } back_state_t;

endpackage

>>> rtl/mcch_front.sv
// front end: takes items, counts the set, classifies and queues commands
module mcch_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  mcch_pkg::in_item_t in_item,
  input  logic             cmd_pop,
  output logic             cmd_empty,
  output mcch_pkg::cmd_t   cmd_head
);
  import mcch_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ov_r, ov_nxt;
  cmd_t             cq_mem [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CQ_AW:0]   lvl_r, lvl_nxt;
  logic             accept, cmd_vld;
  cmd_t             cmd_new;

  assign accept    = in_push && !in_full;
  assign in_full   = (lvl_r == (CQ_AW+1)'(CQ_DEPTH));
  assign cmd_empty = (lvl_r == '0);
  assign cmd_head  = cq_mem[rd_ptr_r];

  // classify
  always_comb begin
    cmd_vld      = 1'b0;
    cmd_new.kind = CMD_STORE;
    cmd_new.pt.x = in_item.point_x;
    cmd_new.pt.y = in_item.point_y;
    count_nxt    = count_r;
    ov_nxt       = ov_r;
    if (accept) begin
      if (in_item.last_in) begin
        cmd_vld   = 1'b1;
        count_nxt = '0;
        ov_nxt    = 1'b0;
        if (ov_r || (count_r == CNT_W'(MAX_POINTS))) begin
          cmd_new.kind = CMD_ERR_OV;
        end else if (count_r < CNT_W'(2)) begin
          cmd_new.kind = CMD_ERR_FEW;
        end else if (count_r == CNT_W'(2)) begin
          cmd_new.kind = CMD_TRIPLE;
        end else begin
          cmd_new.kind = CMD_HULL;
        end
      end else if (count_r < CNT_W'(MAX_POINTS)) begin
        cmd_vld   = 1'b1;
        count_nxt = count_r + CNT_W'(1);
      end else begin
        ov_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    lvl_nxt = lvl_r;
    if (cmd_vld && !(cmd_pop && !cmd_empty)) begin
      lvl_nxt = lvl_r + (CQ_AW+1)'(1);
    end else if (!cmd_vld && cmd_pop && !cmd_empty) begin
      lvl_nxt = lvl_r - (CQ_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ov_r     <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      lvl_r    <= '0;
    end else begin
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      lvl_r   <= lvl_nxt;
      if (cmd_vld) begin
        wr_ptr_r <= wr_ptr_r + CQ_AW'(1);
      end
      if (cmd_pop && !cmd_empty) begin
        rd_ptr_r <= rd_ptr_r + CQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_vld) begin
      cq_mem[wr_ptr_r] <= cmd_new;
    end
  end

endmodule

>>> rtl/mcch_back.sv
// back end: insertion sorter, hull stack walk and vertex emission
module mcch_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_empty,
  input  mcch_pkg::cmd_t      cmd_head,
  output logic                cmd_pop,
  output logic                res_push,
  output mcch_pkg::out_item_t res_item,
  input  logic                res_full
);
  import mcch_pkg::*;

  back_state_t state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [LEN_W-1:0] len_r, len_nxt, base_r, base_nxt, e_r, e_nxt, last_idx, span;
  logic             lower_r, lower_nxt, err_ov_r, err_ov_nxt;
  point_t           pa_r, pa_nxt, pb_r, pb_nxt, pc_r, pc_nxt, push_pt;
  logic signed [DIFF_W-1:0] d1x_r, d1y_r, d2x_r, d2y_r;
  logic signed [DIFF_W-1:0] d1x_nxt, d1y_nxt, d2x_nxt, d2y_nxt;
  logic signed [PROD_W-1:0] m1_r, m2_r, m1_nxt, m2_nxt;
  logic             rturn;

  point_t           srt_r [MAX_POINTS];
  point_t           srt_nxt [MAX_POINTS];
  logic [MAX_POINTS-1:0] gt;
  point_t           first_r [3];
  logic             ins_en;

  point_t           stk_mem [STK_DEPTH];
  point_t           stk_rd_r, stk_wd;
  logic             stk_we, stk_re;
  logic [STK_AW-1:0] stk_wa, stk_ra;

  assign push_pt  = srt_r[i_r[IDX_W-1:0]];
  assign rturn    = (m1_r <= m2_r);
  assign span     = len_r - base_r;
  assign last_idx = (span >= LEN_W'(3)) ? len_r - LEN_W'(2) : base_r - LEN_W'(1);

  // sorter cells: stable insert keeps equal keys in arrival order
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    assign gt[k] = (CNT_W'(k) < fill_r) &&
                   ((srt_r[k].x > cmd_head.pt.x) ||
                    ((srt_r[k].x == cmd_head.pt.x) && (srt_r[k].y > cmd_head.pt.y)));
    if (k == 0) begin : g_first
      always_comb begin
        srt_nxt[k] = srt_r[k];
        if (ins_en && (gt[k] || (fill_r == CNT_W'(k)))) begin
          srt_nxt[k] = cmd_head.pt;
        end
      end
    end else begin : g_rest
      always_comb begin
        srt_nxt[k] = srt_r[k];
        if (ins_en && (gt[k] || (fill_r == CNT_W'(k)))) begin
          srt_nxt[k] = gt[k-1] ? srt_r[k-1] : cmd_head.pt;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!cmd_empty) begin
          case (cmd_head.kind)
            CMD_TRIPLE:  state_nxt = B_TRIPLE;
            CMD_HULL:    state_nxt = B_PUSH;
            CMD_ERR_FEW: state_nxt = B_ERR;
            CMD_ERR_OV:  state_nxt = B_ERR;
            default:     state_nxt = B_IDLE;
          endcase
        end
      end
      B_ERR: begin
        if (!res_full) state_nxt = B_IDLE;
      end
      B_TRIPLE: begin
        if (!res_full && (e_r == LEN_W'(2))) state_nxt = B_IDLE;
      end
      B_PUSH: begin
        state_nxt = (span >= LEN_W'(2)) ? B_DIFF : B_NEXT;
      end
      B_DIFF:   state_nxt = B_MUL;
      B_MUL:    state_nxt = B_CMP;
      B_CMP:    state_nxt = rturn ? B_NEXT : B_RELOAD;
      B_RELOAD: state_nxt = (span >= LEN_W'(3)) ? B_DIFF : B_NEXT;
      B_NEXT: begin
        if (!lower_r) begin
          state_nxt = (i_r == fill_r - CNT_W'(1)) ? B_LPUSH0 : B_PUSH;
        end else begin
          state_nxt = (i_r == '0) ? B_EMIT_RD : B_PUSH;
        end
      end
      B_LPUSH0: state_nxt = B_LPUSH1;
      B_LPUSH1: state_nxt = B_PUSH;
      B_EMIT_RD: begin
        if (e_r != base_r) state_nxt = B_EMIT_WR;
      end
      B_EMIT_WR: begin
        if (!res_full) state_nxt = (e_r == last_idx) ? B_IDLE : B_EMIT_RD;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    fill_nxt   = fill_r;
    i_nxt      = i_r;
    len_nxt    = len_r;
    base_nxt   = base_r;
    e_nxt      = e_r;
    lower_nxt  = lower_r;
    err_ov_nxt = err_ov_r;
    pa_nxt     = pa_r;
    pb_nxt     = pb_r;
    pc_nxt     = pc_r;
    d1x_nxt    = d1x_r;
    d1y_nxt    = d1y_r;
    d2x_nxt    = d2x_r;
    d2y_nxt    = d2y_r;
    m1_nxt     = m1_r;
    m2_nxt     = m2_r;
    ins_en     = 1'b0;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res_item   = '0;
    stk_we     = 1'b0;
    stk_wa     = len_r[STK_AW-1:0];
    stk_wd     = push_pt;
    stk_re     = 1'b0;
    stk_ra     = e_r[STK_AW-1:0];
    case (state_r)
      B_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          case (cmd_head.kind)
            CMD_STORE: begin
              ins_en   = 1'b1;
              fill_nxt = fill_r + CNT_W'(1);
            end
            CMD_TRIPLE: begin
              ins_en   = 1'b1;
              fill_nxt = fill_r + CNT_W'(1);
              e_nxt    = '0;
            end
            CMD_HULL: begin
              ins_en    = 1'b1;
              fill_nxt  = fill_r + CNT_W'(1);
              i_nxt     = '0;
              len_nxt   = '0;
              base_nxt  = '0;
              lower_nxt = 1'b0;
            end
            CMD_ERR_OV: begin
              fill_nxt   = '0;
              err_ov_nxt = 1'b1;
            end
            default: begin
              fill_nxt   = '0;
              err_ov_nxt = 1'b0;
            end
          endcase
        end
      end
      B_ERR: begin
        res_item.last_out = 1'b1;
        res_item.status   = err_ov_r ? ST_OV : ST_FEW;
        res_push          = !res_full;
      end
      B_TRIPLE: begin
        case (e_r[1:0])
          2'd0:    begin res_item.hull_x = first_r[0].x; res_item.hull_y = first_r[0].y; end
          2'd1:    begin res_item.hull_x = first_r[1].x; res_item.hull_y = first_r[1].y; end
          default: begin res_item.hull_x = first_r[2].x; res_item.hull_y = first_r[2].y; end
        endcase
        res_item.last_out = (e_r == LEN_W'(2));
        res_item.status   = ST_OK;
        if (!res_full) begin
          res_push = 1'b1;
          e_nxt    = e_r + LEN_W'(1);
          if (e_r == LEN_W'(2)) fill_nxt = '0;
        end
      end
      B_PUSH, B_LPUSH0, B_LPUSH1: begin
        stk_we  = 1'b1;
        pa_nxt  = pb_r;
        pb_nxt  = pc_r;
        pc_nxt  = push_pt;
        len_nxt = len_r + LEN_W'(1);
        if (state_r != B_PUSH) i_nxt = i_r - CNT_W'(1);
      end
      B_DIFF: begin
        d1x_nxt = DIFF_W'(pb_r.x) - DIFF_W'(pa_r.x);
        d1y_nxt = DIFF_W'(pb_r.y) - DIFF_W'(pa_r.y);
        d2x_nxt = DIFF_W'(pc_r.x) - DIFF_W'(pb_r.x);
        d2y_nxt = DIFF_W'(pc_r.y) - DIFF_W'(pb_r.y);
      end
      B_MUL: begin
        m1_nxt = PROD_W'(d1x_r) * PROD_W'(d2y_r);
        m2_nxt = PROD_W'(d1y_r) * PROD_W'(d2x_r);
      end
      B_CMP: begin
        if (!rturn) begin
          // drop the middle vertex, refetch the one below it
          stk_we  = 1'b1;
          stk_wa  = STK_AW'(len_r - LEN_W'(2));
          stk_wd  = pc_r;
          pb_nxt  = pa_r;
          len_nxt = len_r - LEN_W'(1);
          stk_re  = 1'b1;
          stk_ra  = STK_AW'(len_r - LEN_W'(4));
        end
      end
      B_RELOAD: begin
        pa_nxt = stk_rd_r;
      end
      B_NEXT: begin
        if (!lower_r) begin
          if (i_r == fill_r - CNT_W'(1)) begin
            base_nxt  = len_r;
            lower_nxt = 1'b1;
          end else begin
            i_nxt = i_r + CNT_W'(1);
          end
        end else if (i_r == '0) begin
          e_nxt = '0;
        end else begin
          i_nxt = i_r - CNT_W'(1);
        end
      end
      B_EMIT_RD: begin
        if (e_r == base_r) begin
          e_nxt = e_r + LEN_W'(1);
        end else begin
          stk_re = 1'b1;
        end
      end
      B_EMIT_WR: begin
        res_item.hull_x   = stk_rd_r.x;
        res_item.hull_y   = stk_rd_r.y;
        res_item.last_out = (e_r == last_idx);
        res_item.status   = ST_OK;
        if (!res_full) begin
          res_push = 1'b1;
          if (e_r == last_idx) begin
            fill_nxt = '0;
          end else begin
            e_nxt = e_r + LEN_W'(1);
          end
        end
      end
      default: begin
        fill_nxt = fill_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      fill_r   <= '0;
      i_r      <= '0;
      len_r    <= '0;
      base_r   <= '0;
      e_r      <= '0;
      lower_r  <= 1'b0;
      err_ov_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      i_r      <= i_nxt;
      len_r    <= len_nxt;
      base_r   <= base_nxt;
      e_r      <= e_nxt;
      lower_r  <= lower_nxt;
      err_ov_r <= err_ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pa_r  <= pa_nxt;
    pb_r  <= pb_nxt;
    pc_r  <= pc_nxt;
    d1x_r <= d1x_nxt;
    d1y_r <= d1y_nxt;
    d2x_r <= d2x_nxt;
    d2y_r <= d2y_nxt;
    m1_r  <= m1_nxt;
    m2_r  <= m2_nxt;
    for (int k = 0; k < MAX_POINTS; k++) begin
      srt_r[k] <= srt_nxt[k];
    end
    if (ins_en && (fill_r < CNT_W'(3))) begin
      first_r[fill_r[1:0]] <= cmd_head.pt;
    end
  end

  // hull stack
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_rd_r <= stk_mem[stk_ra];
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(MAX_POINTS))
    else $error("sorter fill beyond capacity");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CMP && !rturn) |=> (len_r == $past(len_r) - LEN_W'(1)))
    else $error("pop did not shrink the stack");

  a_pop_keeps_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CMP && !rturn) |-> (span >= LEN_W'(3)))
    else $error("pop below the chain base");

  a_emit_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_NEXT && lower_r && i_r == '0) |=> (state_r == B_EMIT_RD && e_r == '0))
    else $error("emission did not start at the stack bottom");

endmodule

>>> rtl/mcch_outq.sv
// result queue between the back end and the result ports
module mcch_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_push,
  input  mcch_pkg::out_item_t res_item,
  output logic                res_full,
  input  logic                out_pop,
  output logic                out_empty,
  output mcch_pkg::out_item_t out_item
);
  import mcch_pkg::*;

  out_item_t        oq_mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQ_AW:0]   lvl_r, lvl_nxt;
  logic             do_push, do_pop;

  assign res_full  = (lvl_r == (OQ_AW+1)'(OQ_DEPTH));
  assign out_empty = (lvl_r == '0);
  assign out_item  = oq_mem[rd_ptr_r];
  assign do_push   = res_push && !res_full;
  assign do_pop    = out_pop && !out_empty;

  always_comb begin
    lvl_nxt = lvl_r;
    if (do_push && !do_pop) begin
      lvl_nxt = lvl_r + (OQ_AW+1)'(1);
    end else if (!do_push && do_pop) begin
      lvl_nxt = lvl_r - (OQ_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      lvl_r    <= '0;
    end else begin
      lvl_r <= lvl_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + OQ_AW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + OQ_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      oq_mem[wr_ptr_r] <= res_item;
    end
  end

endmodule

>>> rtl/monotone_chain_convex_hull.sv
// top level: convex hull of a point set by the monotone chain method
// loading: one point per cycle into a four-entry command queue while it is not full; the back
// end sorts each point as it pops it; hull walk: each point is pushed, then a step moves to
// the next point; a turn test takes a difference, a multiply and a compare step, and each
// removed vertex adds a refetch; the lower chain opens with two seed pushes
// synchronous active-low reset empties both queues, no clearing
module monotone_chain_convex_hull (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  mcch_pkg::in_item_t  in_item,
  input  logic                out_pop,
  output logic                out_empty,
  output mcch_pkg::out_item_t out_item
);
  import mcch_pkg::*;

  // command path from front to back
  logic      cmd_pop, cmd_empty;
  cmd_t      cmd_head;
  // result path from back to the output queue
  logic      res_push, res_full;
  out_item_t res_item;

  // front end: counts the set, flags overflow and queues commands
  mcch_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head)
  );

  // back end: sorts, walks both chains and emits each vertex as an item
  // emission: one registered read of the hull stack for each hull vertex
  mcch_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_item  (res_item),
    .res_full  (res_full)
  );

  // result queue so the walk can run ahead of the consumer
  mcch_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_item  (res_item),
    .res_full  (res_full),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

>>> test/monotone_chain_convex_hull_test.sv
// testbench for the monotone chain convex hull block: random and directed point sets
module monotone_chain_convex_hull_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mcch_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_pop;
  logic      out_empty;
  out_item_t out_item;

  monotone_chain_convex_hull u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

  // clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // points not yet offered to the block
  in_item_t  pending_pts[$];
  // hull vertices still owed by the block, oldest first
  out_item_t hull_due[$];

  // predictor copy of the block's state
  point_t    set_pts[MAX_POINTS];
  int        set_count;
  bit        set_overflow;

  int        fail_count;
  int        cycle_count;
  int        sets_done;
  int        vertices_seen;
  int        errors_seen;
  bit        hold_recv;      // long receiver stall requested
  bit        recv_long_done;

  function automatic bit is_before(point_t a, point_t b);
    if (a.x != b.x) return a.x < b.x;
    return a.y < b.y;
  endfunction

  // cross product of (b-a) and (c-b) at most zero means a right turn
  function automatic bit turns_right(point_t a, point_t b, point_t c);
    longint v1x, v1y, v2x, v2y;
    v1x = longint'(b.x) - longint'(a.x);
    v1y = longint'(b.y) - longint'(a.y);
    v2x = longint'(c.x) - longint'(b.x);
    v2y = longint'(c.y) - longint'(b.y);
    return v1x * v2y <= v1y * v2x;
  endfunction

  function automatic out_item_t make_vertex(point_t p, bit fin, logic [1:0] st);
    out_item_t o;
    o.hull_x   = p.x;
    o.hull_y   = p.y;
    o.last_out = fin;
    o.status   = st;
    return o;
  endfunction

  // work out the expected vertices for one accepted point
  task automatic predict_hull(in_item_t it);
    point_t    p;
    point_t    zero_pt;
    int        ord[MAX_POINTS];
    int        stk[2*MAX_POINTS];
    int        len, base, upper_len, n, i, j;
    out_item_t run[$];
    zero_pt = '0;
    p.x = it.point_x;
    p.y = it.point_y;
    if (set_count < MAX_POINTS) begin
      set_pts[set_count] = p;
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (!it.last_in) return;
    n = set_count;
    set_count = 0;
    if (set_overflow) begin
      set_overflow = 1'b0;
      hull_due = {hull_due, make_vertex(zero_pt, 1'b1, ST_OV)};
      return;
    end
    if (n < 3) begin
      hull_due = {hull_due, make_vertex(zero_pt, 1'b1, ST_FEW)};
      return;
    end
    if (n == 3) begin
      for (i = 0; i < 3; i++) hull_due = {hull_due, make_vertex(set_pts[i], i == 2, ST_OK)};
      return;
    end
    // insertion sort on x then y
    for (i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && is_before(set_pts[i], set_pts[ord[j-1]])) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = i;
    end
    // upper chain
    len = 0;
    for (i = 0; i < n; i++) begin
      stk[len] = ord[i];
      len++;
      while (len >= 3 && !turns_right(set_pts[stk[len-3]], set_pts[stk[len-2]],
                                      set_pts[stk[len-1]])) begin
        stk[len-2] = stk[len-1];
        len--;
      end
    end
    upper_len = len;
    // lower chain, right to left
    base = len;
    stk[len] = ord[n-1];
    len++;
    stk[len] = ord[n-2];
    len++;
    for (i = n - 2; i > 0; i--) begin
      stk[len] = ord[i-1];
      len++;
      while (len - base >= 3 && !turns_right(set_pts[stk[len-3]], set_pts[stk[len-2]],
                                             set_pts[stk[len-1]])) begin
        stk[len-2] = stk[len-1];
        len--;
      end
    end
    for (i = 0; i < upper_len; i++) run = {run, make_vertex(set_pts[stk[i]], 1'b0, ST_OK)};
    for (i = base + 1; i + 1 < len; i++)
      run = {run, make_vertex(set_pts[stk[i]], 1'b0, ST_OK)};
    run[run.size()-1].last_out = 1'b1;
    for (i = 0; i < run.size(); i++) hull_due = {hull_due, run[i]};
  endtask

  // coordinate drawn mostly from a small grid so collinear and equal points turn up
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  task automatic queue_set(int n, bit corner);
    in_item_t it;
    int i;
    for (i = 0; i < n; i++) begin
      it.point_x = corner ? (i[0] ? 16'h7fff : 16'h8000) : pick_coord();
      it.point_y = corner ? (i[1] ? 16'h7fff : 16'h8000) : pick_coord();
      it.last_in = (i == n - 1);
      pending_pts = {pending_pts, it};
    end
  endtask

  // driver: offers pending points with random gaps
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push  <= 1'b0;
      send_gap <= 0;
    end else if (in_push && !in_full) begin
      predict_hull(in_item);
      if (pending_pts.size() > 0 && send_gap == 0 && $urandom_range(0, 3) != 0) begin
        in_item <= pending_pts.pop_front();
      end else begin
        in_push  <= 1'b0;
        send_gap <= $urandom_range(0, 14);
      end
    end else if (!in_push) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_pts.size() > 0) begin
        in_item <= pending_pts.pop_front();
        in_push <= 1'b1;
      end
    end
  end

  // monitor: pops hull vertices with random stalls and checks them
  int        recv_gap;
  out_item_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop  <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (hull_due.size() == 0) begin
          $error("hull vertex with nothing expected: x=%0d y=%0d", out_item.hull_x,
                 out_item.hull_y);
          fail_count++;
        end else begin
          want = hull_due.pop_front();
          if (out_item.hull_x !== want.hull_x) begin
            $error("hull_x expected %0d actual %0d", want.hull_x, out_item.hull_x);
            fail_count++;
          end
          if (out_item.hull_y !== want.hull_y) begin
            $error("hull_y expected %0d actual %0d", want.hull_y, out_item.hull_y);
            fail_count++;
          end
          if (out_item.last_out !== want.last_out) begin
            $error("last_out expected %0d actual %0d", want.last_out, out_item.last_out);
            fail_count++;
          end
          if (out_item.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_item.status);
            fail_count++;
          end
          if (want.status == ST_OK) vertices_seen++;
          else errors_seen++;
          if (want.last_out) sets_done++;
        end
      end
      // long hold-off counted here so the block backs up into its input
      if (hold_recv && !recv_long_done) begin
        out_pop  <= 1'b0;
        recv_gap <= 400;
        recv_long_done <= 1'b1;
      end else if (recv_gap > 0) begin
        out_pop  <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else if (out_pop && !out_empty) begin
        // draw the stall before the next vertex; often none
        if ($urandom_range(0, 2) == 0) begin
          out_pop  <= 1'b1;
        end else begin
          out_pop  <= 1'b0;
          recv_gap <= $urandom_range(0, 14);
        end
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_pts.size() > 0 || in_push || hull_due.size() > 0) @(posedge clk);
  endtask

  initial begin
    int i, total;
    in_push        = 1'b0;
    in_item        = '0;
    out_pop        = 1'b0;
    rst_n          = 1'b0;
    set_count      = 0;
    set_overflow   = 1'b0;
    fail_count     = 0;
    cycle_count    = 0;
    sets_done      = 0;
    vertices_seen  = 0;
    errors_seen    = 0;
    hold_recv      = 1'b0;
    recv_long_done = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: too small, exactly three, corners, full store, overflow
    queue_set(1, 1'b0);
    queue_set(2, 1'b1);
    queue_set(3, 1'b1);
    queue_set(4, 1'b1);
    queue_set(5, 1'b0);
    queue_set(MAX_POINTS, 1'b0);
    wait_drained();
    // sender pause until everything has come back
    queue_set(MAX_POINTS + 2, 1'b0);
    wait_drained();

    // long receiver stall while points keep coming
    hold_recv = 1'b1;
    queue_set(20, 1'b0);
    queue_set(12, 1'b0);

    total = 0;
    while (total < 300) begin
      case ($urandom_range(0, 19))
        0:       i = $urandom_range(1, 2);
        1:       i = 3;
        2:       i = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 3);
        3:       i = MAX_POINTS;
        default: i = $urandom_range(4, 14);
      endcase
      queue_set(i, 1'b0);
      total += i;
    end
    wait_drained();
    repeat (200) @(posedge clk);

    $display("covered %0d point sets: %0d hull vertices and %0d error items checked",
             sets_done, vertices_seen, errors_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
